>>> rtl/core/aescbc_pkg.sv
// ----------------------------------------------------------------------------
// aescbc_pkg
// Shared types, register codes and AES byte-level functions for the
// AES-256 CBC core.
// ----------------------------------------------------------------------------
package aescbc_pkg;

    typedef logic [127:0] t_block;
    typedef logic [3:0]   t_rnd;

    // configuration register indexes
    localparam logic [2:0] CFG_KEY0  = 3'd0;
    localparam logic [2:0] CFG_KEY1  = 3'd1;
    localparam logic [2:0] CFG_KEY2  = 3'd2;
    localparam logic [2:0] CFG_KEY3  = 3'd3;
    localparam logic [2:0] CFG_IV_HI = 3'd4;
    localparam logic [2:0] CFG_IV_LO = 3'd5;

    localparam t_rnd LAST_RND = 4'd14;

    typedef struct packed {
        logic        we;
        logic [2:0]  idx;
        logic [63:0] data;
    } t_cfg_wr;

    localparam logic [2047:0] SBOX_V = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [2047:0] INV_SBOX_V = {
        128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX_V[2047 - 8 * int'(x) -: 8];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        return INV_SBOX_V[2047 - 8 * int'(x) -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // byte 0 of a block sits in bits 127:120
    function automatic t_block sub_bytes(input t_block s, input logic inv);
        t_block t;
        for (int i = 0; i < 16; i++) begin
            t[127 - 8 * i -: 8] = inv ? inv_sbox(s[127 - 8 * i -: 8])
                                      : sbox(s[127 - 8 * i -: 8]);
        end
        return t;
    endfunction

    function automatic t_block shift_rows(input t_block s, input logic inv);
        t_block t;
        int     a;
        int     b;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                a = r + 4 * c;
                b = r + 4 * ((c + r) & 3);
                if (inv) begin
                    t[127 - 8 * b -: 8] = s[127 - 8 * a -: 8];
                end else begin
                    t[127 - 8 * a -: 8] = s[127 - 8 * b -: 8];
                end
            end
        end
        return t;
    endfunction

    function automatic t_block mix_columns(input t_block s, input logic inv);
        t_block     t;
        logic [7:0] a [4];
        logic [7:0] x2;
        logic [7:0] x4;
        logic [7:0] x8;
        logic [7:0] m [4][4];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r] = s[127 - 8 * (4 * c + r) -: 8];
            end
            // m[j][k]: a[j] times coefficient k (fwd 2,3,1,1 / inv e,b,d,9)
            for (int j = 0; j < 4; j++) begin
                x2 = xtime(a[j]);
                x4 = xtime(x2);
                x8 = xtime(x4);
                if (inv) begin
                    m[j][0] = x8 ^ x4 ^ x2;
                    m[j][1] = x8 ^ x2 ^ a[j];
                    m[j][2] = x8 ^ x4 ^ a[j];
                    m[j][3] = x8 ^ a[j];
                end else begin
                    m[j][0] = x2;
                    m[j][1] = x2 ^ a[j];
                    m[j][2] = a[j];
                    m[j][3] = a[j];
                end
            end
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * c + r) -: 8] = m[r][0] ^ m[(r + 1) & 3][1]
                                              ^ m[(r + 2) & 3][2] ^ m[(r + 3) & 3][3];
            end
        end
        return t;
    endfunction

endpackage

>>> rtl/core/aescbc_round.sv
// ----------------------------------------------------------------------------
// aescbc_round
// One AES round, forward or inverse, shared by all rounds of a block.
// ----------------------------------------------------------------------------
module aescbc_round (
    input  aescbc_pkg::t_block i_state,
    input  aescbc_pkg::t_block i_rk,
    input  logic               i_dec,
    input  logic               i_final,
    output aescbc_pkg::t_block o_state
);

    aescbc_pkg::t_block enc_t;
    aescbc_pkg::t_block dec_t;

    always_comb begin
        enc_t = aescbc_pkg::shift_rows(aescbc_pkg::sub_bytes(i_state, 1'b0), 1'b0);
        if (!i_final) begin
            enc_t = aescbc_pkg::mix_columns(enc_t, 1'b0);
        end
        enc_t = enc_t ^ i_rk;

        // inverse order: shift, sub, add key, then inverse mix
        dec_t = aescbc_pkg::sub_bytes(aescbc_pkg::shift_rows(i_state, 1'b1), 1'b1) ^ i_rk;
        if (!i_final) begin
            dec_t = aescbc_pkg::mix_columns(dec_t, 1'b1);
        end
    end

    assign o_state = i_dec ? dec_t : enc_t;

endmodule

>>> rtl/core/aescbc_keysched.sv
// ----------------------------------------------------------------------------
// aescbc_keysched
// Key registers and iterative AES-256 key expansion, one round key per cycle.
// ----------------------------------------------------------------------------
module aescbc_keysched (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  aescbc_pkg::t_cfg_wr i_cfg,
    input  aescbc_pkg::t_rnd    i_rk_idx,
    output aescbc_pkg::t_block  o_rk,
    output logic                o_busy
);

    logic [63:0]        r_key [4];
    aescbc_pkg::t_block r_rk [15];
    logic [255:0]       r_win;
    logic [7:0]         r_rcon;
    aescbc_pkg::t_rnd   r_krnd;
    logic               r_busy;

    logic               key_wr;
    logic [31:0]        w7;
    logic [31:0]        t;
    logic [31:0]        n0;
    logic [31:0]        n1;
    logic [31:0]        n2;
    logic [31:0]        n3;

    assign key_wr = i_cfg.we && (i_cfg.idx <= aescbc_pkg::CFG_KEY3);

    always_comb begin
        w7 = r_win[31:0];
        if (r_krnd[0]) begin
            t = aescbc_pkg::sub_word(w7);
        end else begin
            t = aescbc_pkg::sub_word({w7[23:0], w7[31:24]}) ^ {r_rcon, 24'h000000};
        end
        n0 = r_win[255:224] ^ t;
        n1 = r_win[223:192] ^ n0;
        n2 = r_win[191:160] ^ n1;
        n3 = r_win[159:128] ^ n2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_krnd <= '0;
            for (int i = 0; i < 4; i++) begin
                r_key[i] <= '0;
            end
        end else if (key_wr) begin
            r_key[i_cfg.idx[1:0]] <= i_cfg.data;
            r_busy                <= 1'b1;
            r_krnd                <= 4'd1;
        end else if (r_busy) begin
            if (r_krnd == aescbc_pkg::LAST_RND) begin
                r_busy <= 1'b0;
            end else begin
                r_krnd <= r_krnd + 4'd1;
            end
        end
    end

    // schedule storage, no reset: a full expansion writes every entry
    always_ff @(posedge i_clk) begin
        if (!key_wr && r_busy) begin
            if (r_krnd == 4'd1) begin
                r_win  <= {r_key[0], r_key[1], r_key[2], r_key[3]};
                r_rk[0] <= {r_key[0], r_key[1]};
                r_rk[1] <= {r_key[2], r_key[3]};
                r_rcon <= 8'h01;
            end else begin
                r_rk[r_krnd] <= {n0, n1, n2, n3};
                r_win        <= {r_win[127:0], n0, n1, n2, n3};
                if (!r_krnd[0]) begin
                    r_rcon <= aescbc_pkg::xtime(r_rcon);
                end
            end
        end
    end

    assign o_rk   = r_rk[i_rk_idx];
    assign o_busy = r_busy;

endmodule

>>> rtl/core/aes256_cbc_cipher_core.sv
// ----------------------------------------------------------------------------
// aes256_cbc_cipher_core
// AES-256 CBC cipher with PKCS7 padding, one round per cycle on a shared
// round unit.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transaction
//  s_axis    in         one 16-byte block; tuser = {first, mode}
//  m_axis    out        one result block; tuser = pad_error
//  cfg       in         register write: keys 0..3, IV high/low
//
//  A block passes through accept with key add, 14 rounds and finish.
//  A full final encrypt block adds a pad block: key add, rounds, finish.
//  Every key write starts an expansion; input stalls meanwhile.
//  Input is taken while a result still waits; the finish step holds
//  until the output register is free. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module aes256_cbc_cipher_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [63:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,   // in_high, in_low, valid_bytes, zero fill
    input  logic         s_axis_tlast,
    input  logic [1:0]   s_axis_tuser,   // mode, first
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,   // out_high, out_low, out_bytes, zero fill
    output logic         m_axis_tlast,
    output logic [0:0]   m_axis_tuser    // pad_error
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RND,
        S_FIN
    } t_state;

    t_state             r_state;
    aescbc_pkg::t_rnd   r_rnd;
    aescbc_pkg::t_block r_s;
    aescbc_pkg::t_block r_chain;
    aescbc_pkg::t_block r_cin;
    aescbc_pkg::t_block r_iv;
    logic               r_dec;
    logic               r_last;
    logic               r_two;
    logic               r_ov;
    logic               n_ov;
    aescbc_pkg::t_block r_odata;
    logic               r_olast;
    logic [4:0]         r_obytes;
    logic               r_oerr;

    aescbc_pkg::t_cfg_wr cfg;
    aescbc_pkg::t_rnd    rk_idx;
    aescbc_pkg::t_block  rk;
    aescbc_pkg::t_block  rnd_out;
    logic                ks_busy;

    logic               in_acc;
    logic               in_dec;
    logic               in_first;
    logic [4:0]         in_vb;
    aescbc_pkg::t_block in_blk;
    aescbc_pkg::t_block padded;
    aescbc_pkg::t_block chain_eff;
    logic               do_pad;

    aescbc_pkg::t_block res;
    logic [7:0]         pval;
    logic               bad;
    logic               out_free;
    logic [4:0]         fin_bytes;

    assign cfg = '{we: i_cfg_we, idx: i_cfg_idx, data: i_cfg_data};

    aescbc_keysched u_keysched (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_rk_idx (rk_idx),
        .o_rk     (rk),
        .o_busy   (ks_busy)
    );

    aescbc_round u_round (
        .i_state (r_s),
        .i_rk    (rk),
        .i_dec   (r_dec),
        .i_final (r_rnd == aescbc_pkg::LAST_RND),
        .o_state (rnd_out)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !ks_busy;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_dec        = s_axis_tuser[0];
    assign in_first      = s_axis_tuser[1];
    assign in_vb         = s_axis_tdata[132:128];
    assign in_blk        = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    assign chain_eff     = in_first ? r_iv : r_chain;
    // a short final block gets PKCS7 fill; sixteen or more means full
    assign do_pad        = s_axis_tlast && !in_vb[4];
    assign out_free      = !r_ov || m_axis_tready;

    // output valid: drop on acceptance, set when the finish step loads a result
    always_comb begin
        n_ov = r_ov && !m_axis_tready;
        if ((r_state == S_FIN) && out_free) begin
            n_ov = 1'b1;
        end
    end

    // round key select: encrypt walks up from key 0, decrypt down from 14
    always_comb begin
        unique case (r_state)
            S_IDLE:  rk_idx = in_dec ? aescbc_pkg::LAST_RND : 4'd0;
            S_RND:   rk_idx = r_dec ? (aescbc_pkg::LAST_RND - r_rnd) : r_rnd;
            S_FIN:   rk_idx = 4'd0;
            default: rk_idx = 4'd0;
        endcase
    end

    always_comb begin
        padded = in_blk;
        if (do_pad) begin
            for (int i = 0; i < 16; i++) begin
                if (5'(i) >= in_vb) begin
                    padded[127 - 8 * i -: 8] = {3'b000, 5'(5'd16 - in_vb)};
                end
            end
        end
    end

    // finish: unchain a decrypt block, check padding on a final one
    always_comb begin
        res  = r_dec ? (r_s ^ r_chain) : r_s;
        pval = res[7:0];
        bad  = (pval == 8'd0) || (pval > 8'd16);
        for (int i = 0; i < 16; i++) begin
            if ((8'(15 - i) < pval) && (res[127 - 8 * i -: 8] != pval)) begin
                bad = 1'b1;
            end
        end
        if (!r_dec || !r_last) begin
            fin_bytes = 5'd16;
        end else if (bad) begin
            fin_bytes = 5'd0;
        end else begin
            fin_bytes = 5'(5'd16 - pval[4:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rnd   <= '0;
            r_chain <= '0;
            r_iv    <= '0;
            r_ov    <= 1'b0;
            r_two   <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == aescbc_pkg::CFG_IV_HI)) begin
                r_iv[127:64] <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == aescbc_pkg::CFG_IV_LO)) begin
                r_iv[63:0] <= i_cfg_data;
            end
            r_ov <= n_ov;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_s     <= in_dec ? (in_blk ^ rk) : (padded ^ chain_eff ^ rk);
                        r_rnd   <= 4'd1;
                        r_dec   <= in_dec;
                        r_last  <= s_axis_tlast;
                        r_two   <= !in_dec && s_axis_tlast && in_vb[4];
                        r_chain <= chain_eff;
                        r_cin   <= in_blk;
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    r_s <= rnd_out;
                    if (r_rnd == aescbc_pkg::LAST_RND) begin
                        r_state <= S_FIN;
                    end else begin
                        r_rnd <= r_rnd + 4'd1;
                    end
                end
                S_FIN: begin
                    // hold until the output register can take the result
                    if (out_free) begin
                        r_odata  <= res;
                        r_olast  <= r_last && !r_two;
                        r_obytes <= fin_bytes;
                        r_oerr   <= r_dec && r_last && bad;
                        r_chain  <= r_dec ? r_cin : r_s;
                        if (r_two) begin
                            // whole pad block chained on the ciphertext just made
                            r_s     <= {16{8'h10}} ^ r_s ^ rk;
                            r_rnd   <= 4'd1;
                            r_two   <= 1'b0;
                            r_state <= S_RND;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {3'b000, r_obytes, r_odata[63:0], r_odata[127:64]};
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_oerr;

    // no second block while one is in flight
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready)
        else $error("input accepted while a block is in flight");

    // a key write drops input ready as the expansion starts
    a_key_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_idx <= aescbc_pkg::CFG_KEY3)) |=> !s_axis_tready)
        else $error("input ready during key expansion");

    // bad padding only on a final block, with nothing kept
    a_pad_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast && (m_axis_tdata[132:128] == 5'd0)))
        else $error("pad error on a block that keeps bytes");

    // round counter stays within the fourteen rounds
    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RND) |-> ((r_rnd != 4'd0) && (r_rnd <= aescbc_pkg::LAST_RND)))
        else $error("round counter out of range");

endmodule

>>> test/aes256_cbc_cipher_checker.sv
// ----------------------------------------------------------------------------
// aes256_cbc_cipher_checker
// Watches the register port and both streams of the AES-256 CBC core. Keeps
// its own key schedule, IV and chain, computes the blocks that each input
// transaction must produce and compares them with the output stream.
// ----------------------------------------------------------------------------
module aes256_cbc_cipher_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [63:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [135:0] i_s_tdata,
    input  logic         i_s_tlast,
    input  logic [1:0]   i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [135:0] i_m_tdata,
    input  logic         i_m_tlast,
    input  logic [0:0]   i_m_tuser,
    output int           o_fail_count,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        last;
        logic [4:0]  nbytes;
        logic        err;
    } t_cipher_out;

    logic [7:0]   fwd_tab [256];
    logic [7:0]   inv_tab [256];
    logic [63:0]  key_w [4];
    logic [63:0]  iv_w [2];
    logic [127:0] sched [15];
    logic [127:0] chain;
    t_cipher_out  expected_blocks [$];

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return acc;
    endfunction

    // Build the substitution tables from the field inverse and the affine map.
    initial begin
        logic [7:0] v;
        logic [7:0] s;
        for (int x = 0; x < 256; x++) begin
            v = 8'h00;
            for (int y = 1; y < 256; y++) begin
                if (gmul(8'(x), 8'(y)) == 8'h01) v = 8'(y);
            end
            s = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
                ^ {v[3:0], v[7:4]} ^ 8'h63;
            fwd_tab[x] = s;
            inv_tab[s] = 8'(x);
        end
    end

    function automatic logic [31:0] subw(input logic [31:0] w);
        return {fwd_tab[w[31:24]], fwd_tab[w[23:16]], fwd_tab[w[15:8]], fwd_tab[w[7:0]]};
    endfunction

    function automatic void expand_schedule();
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        for (int i = 0; i < 8; i++) begin
            w[i] = (i & 1) ? key_w[i >> 1][31:0] : key_w[i >> 1][63:32];
        end
        for (int i = 8; i < 60; i++) begin
            t = w[i - 1];
            if ((i & 7) == 0) begin
                t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
            end else if ((i & 7) == 4) begin
                t = subw(t);
            end
            w[i] = w[i - 8] ^ t;
        end
        for (int r = 0; r < 15; r++) begin
            sched[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
        end
    endfunction

    // byte i of a block sits in bits 127-8i down
    function automatic logic [127:0] subst(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        for (int i = 0; i < 16; i++) begin
            t[127 - 8 * i -: 8] = inv ? inv_tab[s[127 - 8 * i -: 8]]
                                      : fwd_tab[s[127 - 8 * i -: 8]];
        end
        return t;
    endfunction

    function automatic logic [127:0] rows(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        int           a;
        int           b;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                a = r + 4 * c;
                b = r + 4 * ((c + r) & 3);
                if (inv) t[127 - 8 * b -: 8] = s[127 - 8 * a -: 8];
                else t[127 - 8 * a -: 8] = s[127 - 8 * b -: 8];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] columns(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        logic [7:0]   col [4];
        logic [7:0]   coef [4];
        logic [7:0]   acc;
        if (inv) begin
            coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        end else begin
            coef = '{8'h02, 8'h03, 8'h01, 8'h01};
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) col[r] = s[127 - 8 * (4 * c + r) -: 8];
            for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int j = 0; j < 4; j++) acc ^= gmul(col[j], coef[(j - r + 4) & 3]);
                t[127 - 8 * (4 * c + r) -: 8] = acc;
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] encipher(input logic [127:0] s);
        s ^= sched[0];
        for (int r = 1; r < 14; r++) begin
            s = columns(rows(subst(s, 1'b0), 1'b0), 1'b0) ^ sched[r];
        end
        return rows(subst(s, 1'b0), 1'b0) ^ sched[14];
    endfunction

    function automatic logic [127:0] decipher(input logic [127:0] s);
        s ^= sched[14];
        for (int r = 13; r > 0; r--) begin
            s = columns(subst(rows(s, 1'b1), 1'b1) ^ sched[r], 1'b1);
        end
        return subst(rows(s, 1'b1), 1'b1) ^ sched[0];
    endfunction

    // XOR with the chain, encrypt, advance the chain and queue the block.
    function automatic void chain_encrypt(input logic [127:0] p, input logic fin);
        t_cipher_out e;
        chain = encipher(p ^ chain);
        e.hi = chain[127:64];
        e.lo = chain[63:0];
        e.last = fin;
        e.nbytes = 5'd16;
        e.err = 1'b0;
        expected_blocks.push_back(e);
    endfunction

    function automatic void cbc_predict(input logic mode, input logic first, input logic fin,
                                        input logic [4:0] vb, input logic [127:0] blk);
        t_cipher_out  e;
        logic [127:0] p;
        logic [7:0]   pv;
        logic         bad;
        if (first) chain = {iv_w[0], iv_w[1]};
        if (!mode) begin
            if (!fin) begin
                chain_encrypt(blk, 1'b0);
            end else begin
                if (vb > 5'd16) vb = 5'd16;
                if (vb < 5'd16) begin
                    for (int i = int'(vb); i < 16; i++) blk[127 - 8 * i -: 8] = 8'(16 - vb);
                    chain_encrypt(blk, 1'b1);
                end else begin
                    chain_encrypt(blk, 1'b0);
                    chain_encrypt({16{8'h10}}, 1'b1);
                end
            end
        end else begin
            p = decipher(blk) ^ chain;
            chain = blk;
            e.hi = p[127:64];
            e.lo = p[63:0];
            e.last = fin;
            e.nbytes = 5'd16;
            e.err = 1'b0;
            if (fin) begin
                pv = p[7:0];
                bad = (pv == 8'd0 || pv > 8'd16);
                if (!bad) begin
                    for (int i = 16 - int'(pv); i < 16; i++) begin
                        if (p[127 - 8 * i -: 8] != pv) bad = 1'b1;
                    end
                end
                e.err = bad;
                e.nbytes = bad ? 5'd0 : 5'(16 - pv);
            end
            expected_blocks.push_back(e);
        end
    endfunction

    always @(posedge i_clk) begin
        t_cipher_out e;
        if (!i_rst_n) begin
            key_w = '{default: '0};
            iv_w = '{default: '0};
            chain = '0;
            expected_blocks.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx) inside
                    aescbc_pkg::CFG_KEY0, aescbc_pkg::CFG_KEY1,
                    aescbc_pkg::CFG_KEY2, aescbc_pkg::CFG_KEY3: begin
                        key_w[i_cfg_idx[1:0]] = i_cfg_data;
                        expand_schedule();
                    end
                    aescbc_pkg::CFG_IV_HI: iv_w[0] = i_cfg_data;
                    aescbc_pkg::CFG_IV_LO: iv_w[1] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                cbc_predict(i_s_tuser[0], i_s_tuser[1], i_s_tlast, i_s_tdata[132:128],
                            {i_s_tdata[63:0], i_s_tdata[127:64]});
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_blocks.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) $display("unexpected output block %h", i_m_tdata);
                end else begin
                    e = expected_blocks.pop_front();
                    if (i_m_tdata[63:0] !== e.hi || i_m_tdata[127:64] !== e.lo
                        || i_m_tlast !== e.last || i_m_tdata[132:128] !== e.nbytes
                        || i_m_tuser[0] !== e.err) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("exp hi %h lo %h last %b bytes %0d err %b",
                                     e.hi, e.lo, e.last, e.nbytes, e.err);
                            $display("got hi %h lo %h last %b bytes %0d err %b",
                                     i_m_tdata[63:0], i_m_tdata[127:64], i_m_tlast,
                                     i_m_tdata[132:128], i_m_tuser[0]);
                        end
                    end
                end
            end
        end
        o_pending = expected_blocks.size();
    end

endmodule

>>> test/aes256_cbc_cipher_core_tb.sv
// ----------------------------------------------------------------------------
// aes256_cbc_cipher_core_tb
// Drives the AES-256 CBC core with directed blocks, then random messages:
// mostly encrypt messages whose ciphertext is fed back for decryption, some
// with a damaged block, plus loose random blocks. Runs four idling phases,
// each under a different key and IV. The checker does the comparison.
// ----------------------------------------------------------------------------
module aes256_cbc_cipher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 175;
    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_idx = '0;
    logic [63:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;   // in_high, in_low, valid_bytes, zero fill
    logic         s_axis_tlast = 1'b0;
    logic [1:0]   s_axis_tuser = '0;   // mode, first
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;        // out_high, out_low, out_bytes, zero fill
    logic         m_axis_tlast;
    logic [0:0]   m_axis_tuser;        // pad_error

    int           fail_count;
    int           pending;
    int           cycles = 0;
    int           items = 0;
    int           gap_pct = 0;
    int           stall_pct = 0;
    logic [127:0] cipher_log [$];

    aes256_cbc_cipher_core i_dut (.*);

    aes256_cbc_cipher_checker i_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tlast(s_axis_tlast), .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .i_m_tlast(m_axis_tlast), .i_m_tuser(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    // Hold a watchdog over the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("aes256_cbc_cipher_core: mismatch");
            $finish;
        end
    end

    // Stall the output side at the phase's rate.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Record every accepted output block so encrypted messages can be replayed.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) cipher_log.push_back(m_axis_tdata[127:0]);
    end

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // One input transaction; idle first at the phase's rate, hold until taken.
    task automatic send_block(input logic mode, input logic [63:0] hi, input logic [63:0] lo,
                              input logic first, input logic fin, input logic [4:0] vb);
        logic ok;
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, vb, lo, hi};
        s_axis_tuser <= {first, mode};
        s_axis_tlast <= fin;
        do begin
            @(negedge i_clk);
            ok = s_axis_tready;
            @(posedge i_clk);
        end while (!ok);
        items++;
    endtask

    // Drop valid and wait until every expected block has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // let the output log settle past the last accepted block
        @(posedge i_clk);
    endtask

    // Registers only change while the core is idle, after a drain; the trailing
    // wait covers any expansion still in flight.
    task automatic configure(input logic [63:0] k0, input logic [63:0] k1,
                             input logic [63:0] k2, input logic [63:0] k3,
                             input logic [63:0] ivh, input logic [63:0] ivl);
        logic [63:0] vals [6];
        drain();
        repeat (40) @(posedge i_clk);
        vals = '{k0, k1, k2, k3, ivh, ivl};
        for (int i = 0; i < 6; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= 3'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        // out-of-range indexes must leave everything unchanged
        i_cfg_idx <= 3'd6 + 3'($urandom_range(1));
        i_cfg_data <= rnd64();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        repeat (20) @(posedge i_clk);
    endtask

    // Encrypt a message, then decrypt its ciphertext, sometimes damaged.
    task automatic round_trip(input int nblk, input logic [4:0] vb, input logic damage);
        logic [127:0] ct [$];
        int           k;
        drain();
        cipher_log.delete();
        for (int i = 0; i < nblk; i++) begin
            send_block(MODE_ENC, rnd64(), rnd64(), i == 0, i == nblk - 1,
                       i == nblk - 1 ? vb : 5'($urandom_range(31)));
        end
        drain();
        ct = cipher_log;
        if (damage) begin
            k = $urandom_range(ct.size() - 1);
            ct[k][$urandom_range(127)] ^= 1'b1;
        end
        for (int i = 0; i < ct.size(); i++) begin
            send_block(MODE_DEC, ct[i][63:0], ct[i][127:64], i == 0, i == ct.size() - 1,
                       5'($urandom_range(31)));
        end
    endtask

    task automatic random_phase();
        int start;
        int pick;
        start = items;
        while (items - start < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                round_trip($urandom_range(1, 4),
                           ($urandom_range(3) == 0) ? 5'd16 : 5'($urandom_range(16)),
                           $urandom_range(4) == 0);
            end else begin
                // loose block: any mode, chain flags and byte count
                send_block(1'($urandom_range(1)), rnd64(), rnd64(), $urandom_range(9) < 3,
                           $urandom_range(9) < 4, 5'($urandom_range(31)));
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, zero key and IV first.
        configure('0, '0, '0, '0, '0, '0);
        send_block(MODE_ENC, '0, '0, 1'b1, 1'b1, 5'd0);
        send_block(MODE_ENC, '1, '1, 1'b1, 1'b1, 5'd15);
        send_block(MODE_ENC, '1, '1, 1'b1, 1'b1, 5'd1);
        send_block(MODE_ENC, '1, '0, 1'b1, 1'b1, 5'd16);      // adds a pad block
        send_block(MODE_ENC, rnd64(), rnd64(), 1'b1, 1'b1, 5'd31); // saturates
        send_block(MODE_ENC, rnd64(), rnd64(), 1'b1, 1'b0, 5'd3);  // count ignored
        send_block(MODE_ENC, rnd64(), rnd64(), 1'b0, 1'b0, 5'd0);
        send_block(MODE_DEC, rnd64(), rnd64(), 1'b0, 1'b1, 5'd0);  // mixed, chained
        send_block(MODE_DEC, '0, '0, 1'b1, 1'b1, 5'd0);             // bad padding
        send_block(MODE_DEC, '1, '1, 1'b0, 1'b0, 5'd31);
        send_block(MODE_ENC, rnd64(), rnd64(), 1'b0, 1'b1, 5'd8);  // no first flag
        configure('1, '1, '1, '1, '1, '1);
        round_trip(1, 5'd16, 1'b0);
        round_trip(2, 5'd0, 1'b0);
        round_trip(1, 5'd7, 1'b1);

        // Random phases under different registers and idling.
        configure(rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
        random_phase();
        gap_pct = 52;
        configure(rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
        random_phase();
        gap_pct = 0;
        stall_pct = 52;
        configure('1, '0, '1, '0, '0, '1);
        random_phase();
        gap_pct = 7;
        stall_pct = 7;
        configure(rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
        random_phase();

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("aes256_cbc_cipher_core: match");
        end else begin
            $display("aes256_cbc_cipher_core: mismatch");
        end
        $finish;
    end

endmodule
